// ===== rtl/avgls_pkg.sv =====
// ============================================================================
// avgls_pkg: shared types and constants
// Register codes, fixed arithmetic constants and the exp factor table.
// ============================================================================
package avgls_pkg;

    // Configuration port
    localparam int CFG_AW = 4;

    typedef enum logic [1:0] {
        REG_LOWER_KNEE  = 2'd0,
        REG_UPPER_KNEE  = 2'd1,
        REG_FLOOR_RATIO = 2'd2
    } t_reg_idx;

    localparam logic [15:0] LOWER_KNEE_RST  = 16'hFB00;  // -5 dB in Q8.8
    localparam logic [15:0] UPPER_KNEE_RST  = 16'hFE00;  // -2 dB in Q8.8
    localparam logic [23:0] FLOOR_RATIO_RST = 24'd1678;

    typedef struct packed {
        logic signed [15:0] lower_knee;
        logic signed [15:0] upper_knee;
        logic        [23:0] floor_ratio;
    } t_cfg;

    // Status that the back end reports to the top level
    typedef struct packed {
        logic walking;
    } t_back_stat;

    // Arithmetic constants
    localparam logic [31:0] PEAK_MIN        = 32'd7;
    localparam logic [17:0] DB_PER_LOG2_Q16 = 18'd197283;
    localparam logic [16:0] LOG2E_Q16       = 17'd94548;
    localparam logic [39:0] SUM_MAX         = 40'hFF_FFFF_FFFF;
    localparam logic [24:0] MEAN_MAX        = 25'h100_0000;

    // Shared divider geometry
    localparam int DIV_NW    = 56;
    localparam int DIV_DW    = 32;
    localparam int DIV_CNT_W = 6;

    // Integer square root, used only at elaboration to build the table
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = x;
        res = 64'd0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    typedef logic [15:0][30:0] t_fac_tab;

    // Factors 2^-(2^-(k+1)) in Q1.30, each the square root of the one before
    function automatic t_fac_tab build_exp_fac();
        t_fac_tab    tab;
        logic [63:0] h;
        h = 64'd1 << 29;
        for (int k = 0; k < 16; k++) begin
            h      = isqrt64(h << 30);
            tab[k] = h[30:0];
        end
        return tab;
    endfunction

    localparam t_fac_tab EXP_FAC = build_exp_fac();

endpackage

// ===== rtl/avgls_in_if.sv =====
// ============================================================================
// avgls_in_if: frame input channel
// One beat carries a loudness value and the end-of-block mark.
// ============================================================================
interface avgls_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] loudness;
    logic        last;

    modport source (output valid, output loudness, output last, input ready);
    modport sink   (input valid, input loudness, input last, output ready);
endinterface

// ===== rtl/avgls_out_if.sv =====
// ============================================================================
// avgls_out_if: result channel
// One beat carries the squeezed average loudness and the drop flag.
// ============================================================================
interface avgls_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] squeezed_level;
    logic        dropped;

    modport source (output valid, output squeezed_level, output dropped, input ready);
    modport sink   (input valid, input squeezed_level, input dropped, output ready);
endinterface

// ===== rtl/avgls_ram.sv =====
// ============================================================================
// avgls_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module avgls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/avgls_div.sv =====
// ============================================================================
// avgls_div: shared restoring divider
// Unsigned 56 by 32 bit division, one quotient bit per cycle.
// ============================================================================
module avgls_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [avgls_pkg::DIV_NW-1:0]    i_dividend,
    input  logic [avgls_pkg::DIV_DW-1:0]    i_divisor,
    output logic                            o_done,
    output logic [avgls_pkg::DIV_NW-1:0]    o_quotient
);

    localparam int NW = avgls_pkg::DIV_NW;
    localparam int DW = avgls_pkg::DIV_DW;
    localparam int CNTW = avgls_pkg::DIV_CNT_W;

    logic [NW-1:0]   r_num;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_div;
    logic [CNTW-1:0] r_cnt;
    logic            r_run;
    logic            r_done;

    logic [DW:0]     w_trial;
    logic [DW:0]     w_diff;
    logic            w_ge;

    // One trial subtraction per cycle.
    always_comb begin
        w_trial = {r_rem, r_num[NW-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_ge    = (w_trial >= {1'b0, r_div});
    end

    // Control: a run of NW steps, then a single done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(NW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_num <= {r_num[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_num;

endmodule

// ===== rtl/avgls_front.sv =====
// ============================================================================
// avgls_front: frame intake
// Stores frames, tracks count, peak and overflow, and hands off a job per block.
// ============================================================================
module avgls_front #(
    parameter int MAX_FRAMES = 1024,
    parameter int CW = 11,
    parameter int AW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    avgls_in_if.sink      i_in,
    input  logic          i_hold,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [31:0]   o_wr_data,
    output logic          o_push,
    output logic [CW-1:0] o_job_count,
    output logic [31:0]   o_job_peak,
    output logic          o_job_ovf
);

    logic [CW-1:0] r_count;
    logic [31:0]   r_peak;
    logic          r_ovf;

    logic [CW-1:0] n_count;
    logic [31:0]   n_peak;
    logic          n_ovf;
    logic          w_accept;
    logic          w_room;

    assign i_in.ready = !i_hold;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_room     = (r_count < CW'(MAX_FRAMES));

    // Block statistics including the current beat.
    always_comb begin
        n_count = w_room ? r_count + 1'b1 : r_count;
        n_peak  = (w_room && (i_in.loudness > r_peak)) ? i_in.loudness : r_peak;
        n_ovf   = r_ovf || !w_room;
    end

    // Running state; cleared once a block is handed off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_peak  <= '0;
            r_ovf   <= 1'b0;
        end else if (w_accept) begin
            if (i_in.last) begin
                r_count <= '0;
                r_peak  <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_count <= n_count;
                r_peak  <= n_peak;
                r_ovf   <= n_ovf;
            end
        end
    end

    assign o_wr_en     = w_accept && w_room;
    assign o_wr_addr   = r_count[AW-1:0];
    assign o_wr_data   = i_in.loudness;
    assign o_push      = w_accept && i_in.last;
    assign o_job_count = n_count;
    assign o_job_peak  = n_peak;
    assign o_job_ovf   = n_ovf;

endmodule

// ===== rtl/avgls_jobq.sv =====
// ============================================================================
// avgls_jobq: two-entry job queue
// Decouples the frame intake from the block computation.
// ============================================================================
module avgls_jobq #(
    parameter int WIDTH = 44
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head,
    output logic             o_empty,
    output logic             o_full
);

    logic [WIDTH-1:0] r_slot0;
    logic [WIDTH-1:0] r_slot1;
    logic [1:0]       r_level;

    // Occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 2'd0;
        end else begin
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

    // Entries shift toward the head on a pop.
    always_ff @(posedge i_clk) begin
        case ({i_push, i_pop})
            2'b10: begin
                if (r_level == 2'd0) begin
                    r_slot0 <= i_data;
                end else begin
                    r_slot1 <= i_data;
                end
            end
            2'b01: begin
                r_slot0 <= r_slot1;
            end
            2'b11: begin
                if (r_level == 2'd1) begin
                    r_slot0 <= i_data;
                end else begin
                    r_slot0 <= r_slot1;
                    r_slot1 <= i_data;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_head  = r_slot0;
    assign o_empty = (r_level == 2'd0);
    assign o_full  = (r_level == 2'd2);

endmodule

// ===== rtl/avgls_back.sv =====
// ============================================================================
// avgls_back: block computation
// Walks the store, averages the floored ratios, takes dB and the squeeze curve.
// ============================================================================
module avgls_back #(
    parameter int CW = 11,
    parameter int AW = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  avgls_pkg::t_cfg       i_cfg,
    input  logic                  i_job_valid,
    input  logic [CW-1:0]         i_job_count,
    input  logic [31:0]           i_job_peak,
    input  logic                  i_job_ovf,
    output logic                  o_job_pop,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr,
    input  logic [31:0]           i_rd_data,
    avgls_out_if.source           o_out,
    output avgls_pkg::t_back_stat o_stat
);

    localparam int NW = avgls_pkg::DIV_NW;

    typedef enum logic [15:0] {
        ST_IDLE  = 16'b0000_0000_0000_0001,
        ST_READ  = 16'b0000_0000_0000_0010,
        ST_RATIO = 16'b0000_0000_0000_0100,
        ST_RWAIT = 16'b0000_0000_0000_1000,
        ST_MEAN  = 16'b0000_0000_0001_0000,
        ST_MWAIT = 16'b0000_0000_0010_0000,
        ST_NORM  = 16'b0000_0000_0100_0000,
        ST_LOG   = 16'b0000_0000_1000_0000,
        ST_DB    = 16'b0000_0001_0000_0000,
        ST_KNEE  = 16'b0000_0010_0000_0000,
        ST_VWAIT = 16'b0000_0100_0000_0000,
        ST_EXPB  = 16'b0000_1000_0000_0000,
        ST_EXP   = 16'b0001_0000_0000_0000,
        ST_ODIV  = 16'b0010_0000_0000_0000,
        ST_OWAIT = 16'b0100_0000_0000_0000,
        ST_OUT   = 16'b1000_0000_0000_0000
    } t_state;

    t_state r_state;

    // Job and walk registers
    logic [CW-1:0]      r_cnt;
    logic [31:0]        r_peak;
    logic               r_ovf;
    logic [CW-1:0]      r_idx;
    logic [39:0]        r_sum;
    // Log registers
    logic [24:0]        r_m;
    logic [4:0]         r_sh;
    logic [30:0]        r_y;
    logic [15:0]        r_frac;
    logic [3:0]         r_step;
    logic signed [16:0] r_db;
    // Squeeze registers
    logic               r_vneg;
    logic signed [21:0] r_v;
    logic [20:0]        r_b;
    logic [30:0]        r_prod;
    logic [3:0]         r_k;
    logic [15:0]        r_res;
    // Output register
    logic               r_ovalid;
    logic [15:0]        r_oavg;
    logic               r_odrop;

    // Divider interface
    logic               w_div_start;
    logic [NW-1:0]      w_div_num;
    logic [31:0]        w_div_den;
    logic               w_div_done;
    logic [NW-1:0]      w_quot;

    // Combinational datapath
    logic [24:0]        w_ratio;
    logic [24:0]        w_ratio_fl;
    logic [40:0]        w_sum_add;
    logic [CW-1:0]      w_idx_nx;
    logic [24:0]        w_mean;
    logic [61:0]        w_sq;
    logic [31:0]        w_sq30;
    logic [20:0]        w_mag;
    logic [39:0]        w_mprod;
    logic signed [16:0] w_x1;
    logic signed [16:0] w_x2;
    logic signed [17:0] w_diffn;
    logic signed [16:0] w_den;
    logic [17:0]        w_absn;
    logic [16:0]        w_absd;
    logic [37:0]        w_qmag;
    logic signed [37:0] w_qs;
    logic signed [38:0] w_vraw;
    logic signed [21:0] w_vcl;
    logic [21:0]        w_vabs;
    logic [38:0]        w_bprod;
    logic [62:0]        w_eprod;
    logic [30:0]        w_e;
    logic [31:0]        w_d;
    logic               w_take;

    // Floored peak for the incoming job.
    logic [31:0]        w_peak_fl;
    assign w_peak_fl = (i_job_peak < avgls_pkg::PEAK_MIN) ? avgls_pkg::PEAK_MIN : i_job_peak;

    // Ratio, sum and mean arithmetic.
    always_comb begin
        w_ratio    = w_quot[24:0];
        w_ratio_fl = (w_ratio <= {1'b0, i_cfg.floor_ratio}) ? {1'b0, i_cfg.floor_ratio}
                                                            : w_ratio;
        w_sum_add  = {1'b0, r_sum} + {16'd0, w_ratio_fl};
        w_idx_nx   = r_idx + 1'b1;
        if (w_quot == '0) begin
            w_mean = 25'd1;
        end else if (w_quot > NW'(avgls_pkg::MEAN_MAX)) begin
            w_mean = avgls_pkg::MEAN_MAX;
        end else begin
            w_mean = w_quot[24:0];
        end
    end

    // Log2 squaring step and dB scaling.
    always_comb begin
        w_sq    = {31'd0, r_y} * {31'd0, r_y};
        w_sq30  = w_sq[61:30];
        w_mag   = {r_sh, 16'd0} - {5'd0, r_frac};
        w_mprod = 40'(w_mag) * 40'(avgls_pkg::DB_PER_LOG2_Q16) + 40'h80_0000;
    end

    // Knee offsets and the signed slope quotient.
    always_comb begin
        w_x1    = {i_cfg.lower_knee[15], i_cfg.lower_knee};
        w_x2    = {i_cfg.upper_knee[15], i_cfg.upper_knee};
        w_diffn = {r_db[16], r_db} - {w_x1[16], w_x1};
        w_den   = w_x2 - w_x1;
        w_absn  = w_diffn[17] ? 18'(-w_diffn) : 18'(w_diffn);
        w_absd  = w_den[16] ? 17'(-w_den) : 17'(w_den);
        w_qmag  = {1'b0, w_quot[36:0]};
        w_qs    = r_vneg ? -$signed(w_qmag) : $signed(w_qmag);
        w_vraw  = {w_qs[37], w_qs} - 39'sd131072;
        if (w_vraw > 39'sd1048576) begin
            w_vcl = 22'sd1048576;
        end else if (w_vraw < -39'sd1048576) begin
            w_vcl = -22'sd1048576;
        end else begin
            w_vcl = w_vraw[21:0];
        end
    end

    // Exponent: scale to base 2, factor product, final shift.
    always_comb begin
        w_vabs  = r_v[21] ? 22'(-r_v) : 22'(r_v);
        w_bprod = 39'(w_vabs[20:0]) * 39'(avgls_pkg::LOG2E_Q16) + 39'd32768;
        w_eprod = 63'(r_prod) * 63'(avgls_pkg::EXP_FAC[r_k]) + 63'h2000_0000;
        w_e     = r_prod >> r_b[20:16];
        w_d     = 32'h4000_0000 + {1'b0, w_e};
    end

    // Divider operand selection.
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        case (r_state)
            ST_RATIO: begin
                w_div_start = 1'b1;
                w_div_num   = {i_rd_data, 24'd0};
                w_div_den   = r_peak;
            end
            ST_MEAN: begin
                w_div_start = 1'b1;
                w_div_num   = {16'd0, r_sum};
                w_div_den   = 32'(r_cnt);
            end
            ST_KNEE: begin
                w_div_start = (w_x1 != w_x2);
                w_div_num   = {20'd0, w_absn, 18'd0};
                w_div_den   = {15'd0, w_absd};
            end
            ST_ODIV: begin
                w_div_start = 1'b1;
                w_div_num   = r_v[21] ? ({10'd0, w_e, 15'd0} + NW'(w_d >> 1))
                                      : (56'h2000_0000_0000 + NW'(w_d >> 1));
                w_div_den   = w_d;
            end
            default: begin
            end
        endcase
    end

    avgls_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_take = !r_ovalid || o_out.ready;

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE:  if (i_job_valid) r_state <= ST_READ;
                ST_READ:  r_state <= ST_RATIO;
                ST_RATIO: r_state <= ST_RWAIT;
                ST_RWAIT: begin
                    if (w_div_done) begin
                        r_state <= (w_idx_nx == r_cnt) ? ST_MEAN : ST_READ;
                    end
                end
                ST_MEAN:  r_state <= ST_MWAIT;
                ST_MWAIT: if (w_div_done) r_state <= ST_NORM;
                ST_NORM:  if (r_m[24]) r_state <= ST_LOG;
                ST_LOG:   if (r_step == 4'd15) r_state <= ST_DB;
                ST_DB:    r_state <= ST_KNEE;
                ST_KNEE:  r_state <= (w_x1 == w_x2) ? ST_OUT : ST_VWAIT;
                ST_VWAIT: if (w_div_done) r_state <= ST_EXPB;
                ST_EXPB:  r_state <= ST_EXP;
                ST_EXP:   if (r_k == 4'd15) r_state <= ST_ODIV;
                ST_ODIV:  r_state <= ST_OWAIT;
                ST_OWAIT: if (w_div_done) r_state <= ST_OUT;
                ST_OUT:   if (w_take) r_state <= ST_IDLE;
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cnt  <= i_job_count;
                r_peak <= w_peak_fl;
                r_ovf  <= i_job_ovf;
                r_idx  <= '0;
                r_sum  <= '0;
            end
            ST_RWAIT: begin
                if (w_div_done) begin
                    r_sum <= w_sum_add[40] ? avgls_pkg::SUM_MAX : w_sum_add[39:0];
                    r_idx <= w_idx_nx;
                end
            end
            ST_MWAIT: begin
                r_m  <= w_mean;
                r_sh <= '0;
            end
            ST_NORM: begin
                if (!r_m[24]) begin
                    r_m  <= {r_m[23:0], 1'b0};
                    r_sh <= r_sh + 1'b1;
                end else begin
                    r_y    <= {r_m, 6'd0};
                    r_frac <= '0;
                    r_step <= '0;
                end
            end
            ST_LOG: begin
                r_step <= r_step + 1'b1;
                if (w_sq30[31]) begin
                    r_y    <= w_sq30[31:1];
                    r_frac <= {r_frac[14:0], 1'b1};
                end else begin
                    r_y    <= w_sq30[30:0];
                    r_frac <= {r_frac[14:0], 1'b0};
                end
            end
            ST_DB: begin
                r_db <= -$signed({1'b0, w_mprod[39:24]});
            end
            ST_KNEE: begin
                r_vneg <= w_diffn[17] ^ w_den[16];
                r_res  <= (r_db >= w_x1) ? 16'h8000 : 16'h0000;
            end
            ST_VWAIT: begin
                r_v <= w_vcl;
            end
            ST_EXPB: begin
                r_b    <= w_bprod[36:16];
                r_prod <= 31'h4000_0000;
                r_k    <= '0;
            end
            ST_EXP: begin
                r_k <= r_k + 1'b1;
                if (r_b[4'd15 - r_k]) begin
                    r_prod <= w_eprod[60:30];
                end
            end
            ST_OWAIT: begin
                if (w_div_done) begin
                    r_res <= w_quot[15:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Output register: holds one result while the next block is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == ST_OUT) && w_take) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_OUT) && w_take) begin
            r_oavg  <= r_res;
            r_odrop <= r_ovf;
        end
    end

    assign o_job_pop            = (r_state == ST_IDLE) && i_job_valid;
    assign o_rd_en              = (r_state == ST_READ);
    assign o_rd_addr            = r_idx[AW-1:0];
    assign o_out.valid          = r_ovalid;
    assign o_out.squeezed_level = r_oavg;
    assign o_out.dropped        = r_odrop;
    assign o_stat.walking       = (r_state == ST_READ) || (r_state == ST_RATIO) ||
                                  (r_state == ST_RWAIT);

endmodule

// ===== rtl/average_loudness_squeeze.sv =====
// ============================================================================
// average_loudness_squeeze: squeezed average loudness over a block of frames
// Frames are stored as they arrive; the frame marked last yields one result.
// ============================================================================
// Frames are taken one per cycle while no earlier block is queued or still reading the store.
// After the last frame, the walk makes one 56-step shared divider pass per stored
// frame, then works out the mean, the log and the squeeze curve.
// The result sits in an output register, so the next block loads while it waits.
// Reset is synchronous, active low; it clears control state and the configuration registers
// to their defaults; the frame store is not cleared.
module average_loudness_squeeze #(
    parameter int MAX_FRAMES = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    avgls_in_if.sink                     i_in,
    avgls_out_if.source                  o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [avgls_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int AW = $clog2(MAX_FRAMES);
    localparam int JW = CW + 33;

    avgls_pkg::t_cfg       r_cfg;
    avgls_pkg::t_back_stat w_stat;
    avgls_pkg::t_reg_idx   w_reg;

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [31:0]   w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [31:0]   w_rd_data;
    logic          w_push;
    logic [CW-1:0] w_job_count;
    logic [31:0]   w_job_peak;
    logic          w_job_ovf;
    logic [JW-1:0] w_head;
    logic          w_q_empty;
    logic          w_q_full;
    logic          w_pop;
    logic          w_hold;

    // Configuration registers on the APB port.
    assign pready = 1'b1;
    assign w_reg  = avgls_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_knee  <= avgls_pkg::LOWER_KNEE_RST;
            r_cfg.upper_knee  <= avgls_pkg::UPPER_KNEE_RST;
            r_cfg.floor_ratio <= avgls_pkg::FLOOR_RATIO_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (w_reg)
                avgls_pkg::REG_LOWER_KNEE:  r_cfg.lower_knee  <= pwdata[15:0];
                avgls_pkg::REG_UPPER_KNEE:  r_cfg.upper_knee  <= pwdata[15:0];
                avgls_pkg::REG_FLOOR_RATIO: r_cfg.floor_ratio <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            avgls_pkg::REG_LOWER_KNEE:  prdata = {16'd0, r_cfg.lower_knee};
            avgls_pkg::REG_UPPER_KNEE:  prdata = {16'd0, r_cfg.upper_knee};
            avgls_pkg::REG_FLOOR_RATIO: prdata = {8'd0, r_cfg.floor_ratio};
            default:                    prdata = 32'd0;
        endcase
    end

    // Intake stalls while a block is queued or its frames are being read.
    assign w_hold = !w_q_empty || w_stat.walking;

    avgls_front #(
        .MAX_FRAMES (MAX_FRAMES),
        .CW         (CW),
        .AW         (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_hold      (w_hold),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_push      (w_push),
        .o_job_count (w_job_count),
        .o_job_peak  (w_job_peak),
        .o_job_ovf   (w_job_ovf)
    );

    avgls_ram #(
        .WIDTH (32),
        .DEPTH (MAX_FRAMES)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    avgls_jobq #(
        .WIDTH (JW)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_job_ovf, w_job_peak, w_job_count}),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    avgls_back #(
        .CW (CW),
        .AW (AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (!w_q_empty),
        .i_job_count (w_head[CW-1:0]),
        .i_job_peak  (w_head[CW+31:CW]),
        .i_job_ovf   (w_head[JW-1]),
        .o_job_pop   (w_pop),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_out       (o_out),
        .o_stat      (w_stat)
    );

    // The store is never written while the back end reads it.
    a_no_load_during_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> !w_stat.walking)
        else $error("frame written while store walk in progress");

    // A job is never pushed into a full queue.
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("job queue overflow");

    // A delivered level never exceeds one in Q1.15.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.squeezed_level <= 16'h8000))
        else $error("result out of range");

    // A pop only happens with a job waiting.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("job popped from empty queue");

endmodule
